// ===== design/top_k_candidate_ranker_macros.svh =====
// Assertion macros for the top-k candidate ranker.
// Used by the top level; depends on nothing else.
`ifndef TOP_K_CANDIDATE_RANKER_MACROS_SVH
`define TOP_K_CANDIDATE_RANKER_MACROS_SVH

// same-cycle implication
`define TKR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tkr_pkg.sv =====
// Shared types and constants of the top-k candidate ranker.
// No dependencies.
package tkr_pkg;

    localparam int unsigned SCORE_W    = 17;
    localparam int unsigned ID_W       = 8;
    localparam int unsigned RANK_W     = 3;
    localparam int unsigned CFG_W      = 17;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_MIN_CONFIDENCE = 1'b0;
    localparam t_cfg_index CFG_MIN_MARGIN     = 1'b1;

    localparam logic [CFG_W-1:0] MIN_CONFIDENCE_RST = 17'd39322;
    localparam logic [CFG_W-1:0] MIN_MARGIN_RST     = 17'd6554;

    typedef struct packed {
        logic [ID_W-1:0]    command_id;
        logic [SCORE_W-1:0] score;
        logic               last_candidate;
    } t_item;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [ID_W-1:0]    ranked_id;
        logic [SCORE_W-1:0] ranked_score;
        logic               confident;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic insert;
        logic latch_conf;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic head_last;
    } t_status;

endpackage

// ===== design/tkr_controller.sv =====
// Sequencer of the top-k candidate ranker: accept, rank, emit.
// Depends on tkr_pkg.
module tkr_controller
    import tkr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RANK,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_stall;

    always_comb begin
        o_cmd            = '0;
        o_cmd.insert     = i_in_valid && !r_in_stall;
        o_cmd.latch_conf = (r_state == S_RANK);
        o_cmd.pop        = (r_state == S_EMIT) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.insert && i_in_last) begin
                        r_state    <= S_RANK;
                        r_in_stall <= 1'b1;
                    end
                end
                S_RANK: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_cmd.pop && i_status.head_last) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// ===== design/tkr_datapath.sv =====
// Insertion row, thresholds, confidence and output register of the ranker.
// Depends on tkr_pkg.
module tkr_datapath
    import tkr_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_item            i_item,
    input  logic             i_cfg_we,
    input  t_cfg_index       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    output t_status          o_status,
    output logic             o_out_valid,
    output t_result          o_out_item
);

    logic [ID_W-1:0]    r_id    [LIST_DEPTH];
    logic [SCORE_W-1:0] r_score [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] r_valid;
    logic [LIST_DEPTH-1:0] w_ge;

    logic [CFG_W-1:0]  r_min_conf;
    logic [CFG_W-1:0]  r_min_margin;
    logic              r_conf;
    logic [RANK_W-1:0] r_rank;
    logic              r_out_valid;
    t_result           r_out;

    logic [SCORE_W-1:0] w_sc;
    logic               w_second_valid;
    logic [SCORE_W-1:0] w_second_score;
    logic [SCORE_W-1:0] w_lead;
    logic               n_conf;

    assign w_sc = (i_item.score > SCORE_ONE) ? SCORE_ONE : i_item.score;

    // ge is a thermometer: valid entries are sorted, empty ones sit at the tail
    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            logic               w_prev_ge;
            logic               w_prev_valid;
            logic [ID_W-1:0]    w_prev_id;
            logic [SCORE_W-1:0] w_prev_score;
            logic               w_next_valid;
            logic [ID_W-1:0]    w_next_id;
            logic [SCORE_W-1:0] w_next_score;

            assign w_ge[gi] = !r_valid[gi] || (w_sc > r_score[gi]);

            if (gi == 0) begin : g_head
                assign w_prev_ge    = 1'b0;
                assign w_prev_valid = 1'b0;
                assign w_prev_id    = '0;
                assign w_prev_score = '0;
            end else begin : g_body
                assign w_prev_ge    = w_ge[gi-1];
                assign w_prev_valid = r_valid[gi-1];
                assign w_prev_id    = r_id[gi-1];
                assign w_prev_score = r_score[gi-1];
            end

            if (gi == LIST_DEPTH - 1) begin : g_tail
                assign w_next_valid = 1'b0;
                assign w_next_id    = '0;
                assign w_next_score = '0;
            end else begin : g_inner
                assign w_next_valid = r_valid[gi+1];
                assign w_next_id    = r_id[gi+1];
                assign w_next_score = r_score[gi+1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[gi] <= 1'b0;
                end else if (i_cmd.insert) begin
                    if (w_prev_ge) begin
                        r_valid[gi] <= w_prev_valid;
                    end else if (w_ge[gi]) begin
                        r_valid[gi] <= 1'b1;
                    end
                end else if (i_cmd.pop) begin
                    r_valid[gi] <= w_next_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.insert) begin
                    if (w_prev_ge) begin
                        r_id[gi]    <= w_prev_id;
                        r_score[gi] <= w_prev_score;
                    end else if (w_ge[gi]) begin
                        r_id[gi]    <= i_item.command_id;
                        r_score[gi] <= w_sc;
                    end
                end else if (i_cmd.pop) begin
                    r_id[gi]    <= w_next_id;
                    r_score[gi] <= w_next_score;
                end
            end
        end

        if (LIST_DEPTH > 1) begin : g_second
            assign w_second_valid = r_valid[1];
            assign w_second_score = r_score[1];
        end else begin : g_single
            assign w_second_valid = 1'b0;
            assign w_second_score = '0;
        end
    endgenerate

    assign w_lead = r_score[0] - w_second_score;
    assign n_conf = (r_score[0] >= r_min_conf)
                 && !(w_second_valid && (w_lead < r_min_margin));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf   <= MIN_CONFIDENCE_RST;
            r_min_margin <= MIN_MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_CONFIDENCE: r_min_conf   <= i_cfg_data;
                CFG_MIN_MARGIN:     r_min_margin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank      <= '0;
            r_conf      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.latch_conf) begin
                r_rank <= '0;
                r_conf <= n_conf;
            end else if (i_cmd.pop) begin
                r_rank <= r_rank + 1'b1;
            end
            if (i_cmd.pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_out.rank         <= r_rank;
            r_out.ranked_id    <= r_id[0];
            r_out.ranked_score <= r_score[0];
            r_out.confident    <= r_conf;
            r_out.last_result  <= !w_second_valid;
        end
    end

    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_status.head_last = !w_second_valid;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule

// ===== design/top_k_candidate_ranker.sv =====
// Top level of the top-k candidate ranker: controller plus datapath.
// Depends on tkr_pkg, tkr_controller, tkr_datapath and the assertion macros.
//
//   port group   dir  handshake                 payload
//   in           in   i_in_valid / o_in_stall   i_in_item  (t_item)
//   out          out  o_out_valid / i_out_stall o_out_item (t_result)
//   cfg          in   i_cfg_we                  i_cfg_index, i_cfg_data
//
// Items without the last mark are inserted into the row; they may follow back to back.
// An item with the last mark is inserted too, then confidence is latched (S_RANK),
// then results are popped one by one from the head of the row (S_EMIT).
// Synchronous active-low reset empties the list and output, presets thresholds.
// Output stall holds the popping of the row; input stays stalled until the
// final result is loaded into the output register.
`include "top_k_candidate_ranker_macros.svh"

module top_k_candidate_ranker
    import tkr_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_item            i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_result          o_out_item,
    input  logic             i_cfg_we,
    input  t_cfg_index       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    tkr_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_item.last_candidate),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    tkr_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `TKR_ASSERT_NOW(a_stall_mid_emit, i_clk, i_rst_n,
        o_out_valid && !o_out_item.last_result, o_in_stall,
        "input taken while results remain")
    `TKR_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item),
        "stalled result changed or dropped")
    `TKR_ASSERT_NEXT(a_conf_steady, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_item.last_result,
        o_out_item.confident == $past(o_out_item.confident),
        "confidence changed within one ranking")

endmodule

// ===== dv/testbench.sv =====
// Testbench for top_k_candidate_ranker: random bursts of candidates against a
// built-in ranking predictor, with threshold changes between quiet phases.
// Depends on tkr_pkg and the top_k_candidate_ranker RTL.
module testbench;
    import tkr_pkg::*;

    localparam int DEPTH = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_item            in_item = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_result          out_item;
    logic             cfg_we = 1'b0;
    t_cfg_index       cfg_index = CFG_MIN_CONFIDENCE;
    logic [CFG_W-1:0] cfg_data = '0;

    t_item              candidate_q [$];
    t_result            ranking_q [$];
    logic [ID_W-1:0]    held_ids [DEPTH] = '{default: '0};
    logic [SCORE_W-1:0] held_scores [DEPTH] = '{default: '0};
    int                 held_count = 0;
    logic [CFG_W-1:0]   min_conf = MIN_CONFIDENCE_RST;
    logic [CFG_W-1:0]   min_margin = MIN_MARGIN_RST;
    int                 pushed_count = 0;
    int                 accepted_count = 0;
    int                 fail_count = 0;
    int                 burst_left = 1;
    int                 gap_left = 0;
    int unsigned        stall_cycle = 0;
    int unsigned        stall_mode = 0;

    top_k_candidate_ranker #(.LIST_DEPTH(DEPTH)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Insert one candidate into the predicted list; on the last mark, queue the
    // ranked results and clear the list.
    function automatic void rank_candidate(t_item cand);
        logic [SCORE_W-1:0] sc;
        logic               sure;
        t_result            res;
        int                 pos;
        int                 i;
        sc = (cand.score > SCORE_ONE) ? SCORE_ONE : cand.score;
        pos = held_count;
        for (i = held_count - 1; i >= 0; i--) begin
            if (sc > held_scores[i]) pos = i;
        end
        if (pos < DEPTH) begin
            for (i = (held_count < DEPTH) ? held_count : DEPTH - 1; i > pos; i--) begin
                held_ids[i] = held_ids[i-1];
                held_scores[i] = held_scores[i-1];
            end
            held_ids[pos] = cand.command_id;
            held_scores[pos] = sc;
            if (held_count < DEPTH) held_count++;
        end
        if (cand.last_candidate) begin
            sure = (held_scores[0] >= min_conf) &&
                   (held_count < 2 || (held_scores[0] - held_scores[1]) >= min_margin);
            for (i = 0; i < held_count; i++) begin
                res.rank = RANK_W'(i);
                res.ranked_id = held_ids[i];
                res.ranked_score = held_scores[i];
                res.confident = sure;
                res.last_result = (i == held_count - 1);
                ranking_q.push_back(res);
            end
            for (i = 0; i < DEPTH; i++) begin
                held_ids[i] = '0;
                held_scores[i] = '0;
            end
            held_count = 0;
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void queue_candidate(logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc,
                                            logic last);
        t_item it;
        it.command_id = id;
        it.score = sc;
        it.last_candidate = last;
        candidate_q.push_back(it);
        pushed_count++;
    endfunction

    task automatic set_threshold(t_cfg_index idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_CONFIDENCE) min_conf = val;
        else min_margin = val;
    endtask

    task automatic drain(int settle);
        while (accepted_count != pushed_count || ranking_q.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                rank_candidate(in_item);
                accepted_count++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0 || candidate_q.size() == 0) begin
                    in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    in_item <= candidate_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 5))
                            0, 1, 2: gap_left = 0;
                            3, 4:    gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(5, 20);
                        endcase
                    end
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 48 == 47) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_cycle % 16 < 11);
        endcase
    end

    // monitor
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (ranking_q.size() == 0) begin
                $error("unexpected result: rank %0d id %0d score %0d",
                       out_item.rank, out_item.ranked_id, out_item.ranked_score);
                fail_count++;
            end else begin
                want = ranking_q.pop_front();
                check_field("rank", want.rank, out_item.rank);
                check_field("ranked_id", want.ranked_id, out_item.ranked_id);
                check_field("ranked_score", want.ranked_score, out_item.ranked_score);
                check_field("confident", want.confident, out_item.confident);
                check_field("last_result", want.last_result, out_item.last_result);
            end
        end
    end

    initial begin
        #6000000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int                 phase;
        int                 n;
        int                 len;
        int                 i;
        logic               noisy;
        logic               last;
        logic [SCORE_W-1:0] anchor;
        logic [SCORE_W-1:0] sc;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single entries: zero score, saturated score, top exactly at threshold
        queue_candidate(8'd0, 17'd0, 1'b1);
        queue_candidate(8'hFF, 17'h1FFFF, 1'b1);
        queue_candidate(8'd24, 17'd39322, 1'b1);
        // ties keep arrival order
        queue_candidate(8'd1, 17'd5000, 1'b0);
        queue_candidate(8'd2, 17'd5000, 1'b0);
        queue_candidate(8'd3, 17'd5000, 1'b0);
        queue_candidate(8'd4, 17'd5000, 1'b1);
        // full list: newcomer dropped, then a new best pushes the lowest out
        for (i = 0; i < 9; i++) queue_candidate(8'(10 + i), 17'(60000 - 1000 * i), 1'b0);
        queue_candidate(8'd19, SCORE_ONE, 1'b1);
        // margin exactly met, then missed by one
        queue_candidate(8'd20, 17'd50000, 1'b0);
        queue_candidate(8'd21, 17'd43446, 1'b1);
        queue_candidate(8'd22, 17'd50000, 1'b0);
        queue_candidate(8'd23, 17'd43447, 1'b1);

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: ;
                1: begin
                    set_threshold(CFG_MIN_CONFIDENCE, '0);
                    set_threshold(CFG_MIN_MARGIN, '0);
                end
                2: begin
                    set_threshold(CFG_MIN_CONFIDENCE, SCORE_ONE);
                    set_threshold(CFG_MIN_MARGIN, SCORE_ONE);
                end
                3: begin
                    set_threshold(CFG_MIN_CONFIDENCE, 17'h1FFFF);
                    set_threshold(CFG_MIN_MARGIN, 17'h1FFFF);
                end
                4: begin
                    set_threshold(CFG_MIN_CONFIDENCE, '0);
                end
                5: begin
                    set_threshold(CFG_MIN_CONFIDENCE, 17'h10001);
                    set_threshold(CFG_MIN_MARGIN, '0);
                end
                6: begin
                    set_threshold(CFG_MIN_CONFIDENCE, 17'($urandom_range(20000, 60000)));
                    set_threshold(CFG_MIN_MARGIN, 17'($urandom_range(1, 20000)));
                end
                default: begin
                    set_threshold(CFG_MIN_CONFIDENCE, MIN_CONFIDENCE_RST);
                    set_threshold(CFG_MIN_MARGIN, MIN_MARGIN_RST);
                end
            endcase

            n = 0;
            while (n < 50) begin
                anchor = ($urandom_range(0, 3) == 0) ? min_conf : 17'($urandom_range(0, 65536));
                noisy = ($urandom_range(0, 7) == 0);
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    if (noisy) begin
                        sc = 17'($urandom_range(0, 131071));
                        last = (i == len - 1) || ($urandom_range(0, 3) == 0);
                    end else begin
                        case ($urandom_range(0, 11))
                            0:       sc = '0;
                            1:       sc = SCORE_ONE;
                            2:       sc = 17'($urandom_range(65537, 131071));
                            3, 4:    sc = anchor;
                            5:       sc = anchor - min_margin;
                            6:       sc = anchor - min_margin + 1'b1;
                            7:       sc = anchor ^ 17'($urandom_range(0, 15));
                            default: sc = 17'($urandom_range(0, 65536));
                        endcase
                        last = (i == len - 1);
                    end
                    queue_candidate(8'($urandom_range(0, 255)), sc, last);
                end
                n += len;
            end
            drain(8);
        end

        drain(20);
        if (fail_count == 0 && ranking_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
